[rtl/core/ctsch_pkg.sv]
`default_nettype none

package ctsch_pkg;

  // Default sizing of the slot table
  localparam int NUM_SLOTS_DEF      = 8;
  localparam int RUN_COUNT_BITS_DEF = 8;
  // Most results one dispatch may return
  localparam int MAX_RESULTS        = 8;
  localparam int TICK_W             = 32;
  localparam int SLOT_FIELD_W       = 3;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_DISP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                   mode;
    logic [TICK_W-1:0]       delay_ticks;
    logic [TICK_W-1:0]       period_ticks;
    logic [SLOT_FIELD_W-1:0] slot;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [SLOT_FIELD_W-1:0] slot_index;
    logic                    last;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/core/ctsch_ram.sv]
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module ctsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/ctsch_slot_alu.sv]
`default_nettype none

// Shared slot update unit: one slot record in, its next value out
module ctsch_slot_alu #(
  parameter int RUN_W = ctsch_pkg::RUN_COUNT_BITS_DEF
) (
  input  wire ctsch_pkg::mode_t               op,
  input  wire logic [ctsch_pkg::TICK_W-1:0]   delay_i,
  input  wire logic [ctsch_pkg::TICK_W-1:0]   period_i,
  input  wire logic [RUN_W-1:0]               pend_i,
  output logic      [ctsch_pkg::TICK_W-1:0]   delay_o,
  output logic      [RUN_W-1:0]               pend_o
);

  logic at_zero;
  logic pend_full;

  assign at_zero   = (delay_i == '0);
  assign pend_full = (pend_i == {RUN_W{1'b1}});

  always_comb begin
    delay_o = delay_i;
    pend_o  = pend_i;
    unique case (op)
      ctsch_pkg::MODE_TICK: begin
        if (at_zero) begin
          // due: one more run (saturating), reload when periodic
          if (!pend_full) begin
            pend_o = pend_i + RUN_W'(1);
          end
          if (period_i != '0) begin
            delay_o = period_i;
          end
        end else begin
          delay_o = delay_i - ctsch_pkg::TICK_W'(1);
        end
      end
      ctsch_pkg::MODE_DISP: begin
        pend_o = pend_i - RUN_W'(1);
      end
      default: begin
        delay_o = delay_i;
        pend_o  = pend_i;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/cooperative_task_scheduler.sv]
`default_nettype none

// Channel   Ports                         Handshake
// -------   ---------------------------   ---------------------------------
// input     start, busy, in_item          taken when start && !busy
// result    out_valid, out_item           one-cycle strobe, no back-pressure
//
// Each slot is visited at most once per item. A skipped slot is only scanned; a
// slot that is read and rewritten through the slot RAM is read (registered), then
// written. Tick visits every slot, dispatch stops at its last result, add at the
// first free slot; each result shows on the cycle after it is formed.
// Reset clears the used and pending marks at once; the RAM needs no clearing.
// The receiver cannot stall, so busy depends on the sequencer alone.
module cooperative_task_scheduler #(
  parameter int NUM_SLOTS      = ctsch_pkg::NUM_SLOTS_DEF,
  parameter int RUN_COUNT_BITS = ctsch_pkg::RUN_COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ctsch_pkg::in_item_t  in_item,
  output logic                      out_valid,
  output ctsch_pkg::out_item_t      out_item
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TW     = ctsch_pkg::TICK_W;
  localparam int REC_W  = 2 * TW + RUN_COUNT_BITS;
  localparam int NR_W   = (ctsch_pkg::MAX_RESULTS > 1) ? $clog2(ctsch_pkg::MAX_RESULTS) : 1;
  localparam int CMP_W  = 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PROC
  } state_t;

  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic [NR_W-1:0]         n_r, n_nxt;
  ctsch_pkg::in_item_t     cmd_r, cmd_nxt;
  logic [NUM_SLOTS-1:0]    used_r, used_nxt;
  logic [NUM_SLOTS-1:0]    pnz_r, pnz_nxt;
  logic                    out_valid_r, out_valid_nxt;
  ctsch_pkg::out_item_t    out_item_r, out_item_nxt;

  // RAM and slot unit wiring
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic [REC_W-1:0]        ram_wdata;
  logic [REC_W-1:0]        ram_rdata;
  logic [TW-1:0]           rd_delay, rd_period, alu_delay;
  logic [RUN_COUNT_BITS-1:0] rd_pend, alu_pend;

  logic [NUM_SLOTS-1:0]    ready;
  logic                    ready_above;
  logic                    at_end;
  logic                    sel_ok;
  logic [SLOT_W-1:0]       sel_idx;
  logic                    disp_last;
  logic                    advance;

  assign rd_delay  = ram_rdata[REC_W-1 -: TW];
  assign rd_period = ram_rdata[RUN_COUNT_BITS +: TW];
  assign rd_pend   = ram_rdata[RUN_COUNT_BITS-1:0];

  ctsch_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  ctsch_slot_alu #(
    .RUN_W (RUN_COUNT_BITS)
  ) u_alu (
    .op       (cmd_r.mode),
    .delay_i  (rd_delay),
    .period_i (rd_period),
    .pend_i   (rd_pend),
    .delay_o  (alu_delay),
    .pend_o   (alu_pend)
  );

  // Slots with runs waiting, and whether any lies above the current one
  assign ready = used_r & pnz_r;

  always_comb begin
    ready_above = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (ready[j] && (SLOT_W'(j) > idx_r)) begin
        ready_above = 1'b1;
      end
    end
  end

  assign at_end    = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign sel_ok    = (CMP_W'(cmd_r.slot) < CMP_W'(NUM_SLOTS));
  assign sel_idx   = SLOT_W'(cmd_r.slot);
  assign disp_last = !ready_above || (n_r == NR_W'(ctsch_pkg::MAX_RESULTS - 1));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    cmd_nxt       = cmd_r;
    used_nxt      = used_r;
    pnz_nxt       = pnz_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r;
    ram_wdata     = {alu_delay, rd_period, alu_pend};
    advance       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_item;
          idx_nxt   = '0;
          n_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        unique case (cmd_r.mode)
          ctsch_pkg::MODE_TICK: begin
            if (used_r[idx_r]) begin
              state_nxt = S_PROC;
            end else begin
              advance = 1'b1;
            end
          end
          ctsch_pkg::MODE_ADD: begin
            if (!used_r[idx_r]) begin
              // first free slot takes the new task
              ram_we                  = 1'b1;
              ram_wdata               = {cmd_r.delay_ticks, cmd_r.period_ticks,
                                         {RUN_COUNT_BITS{1'b0}}};
              used_nxt[idx_r]         = 1'b1;
              pnz_nxt[idx_r]          = 1'b0;
              out_valid_nxt           = 1'b1;
              out_item_nxt.status     = ctsch_pkg::ST_OK;
              out_item_nxt.slot_index = ctsch_pkg::SLOT_FIELD_W'(idx_r);
              out_item_nxt.last       = 1'b1;
              state_nxt               = S_IDLE;
            end else begin
              advance = 1'b1;
            end
          end
          ctsch_pkg::MODE_DEL: begin
            out_valid_nxt           = 1'b1;
            out_item_nxt.slot_index = cmd_r.slot;
            out_item_nxt.last       = 1'b1;
            if (sel_ok && used_r[sel_idx]) begin
              used_nxt[sel_idx]   = 1'b0;
              pnz_nxt[sel_idx]    = 1'b0;
              out_item_nxt.status = ctsch_pkg::ST_OK;
            end else begin
              out_item_nxt.status = ctsch_pkg::ST_ERR;
            end
            state_nxt = S_IDLE;
          end
          ctsch_pkg::MODE_DISP: begin
            if (ready[idx_r]) begin
              state_nxt = S_PROC;
            end else begin
              advance = 1'b1;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_PROC: begin
        // read data for idx_r is valid now; write back the update
        ram_we         = 1'b1;
        pnz_nxt[idx_r] = (alu_pend != '0);
        if (cmd_r.mode == ctsch_pkg::MODE_DISP) begin
          if (rd_period == '0) begin
            used_nxt[idx_r] = 1'b0;
            pnz_nxt[idx_r]  = 1'b0;
          end
          out_valid_nxt           = 1'b1;
          out_item_nxt.status     = ctsch_pkg::ST_OK;
          out_item_nxt.slot_index = ctsch_pkg::SLOT_FIELD_W'(idx_r);
          out_item_nxt.last       = disp_last;
          n_nxt                   = n_r + NR_W'(1);
          if (disp_last) begin
            state_nxt = S_IDLE;
          end else begin
            advance = 1'b1;
          end
        end else begin
          advance = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // step to the next slot, or close out the item after the last one
    if (advance) begin
      if (at_end) begin
        state_nxt               = S_IDLE;
        out_item_nxt.slot_index = '0;
        out_item_nxt.last       = 1'b1;
        unique case (cmd_r.mode)
          ctsch_pkg::MODE_TICK: begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ctsch_pkg::ST_OK;
          end
          ctsch_pkg::MODE_ADD: begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ctsch_pkg::ST_ERR;
          end
          default: begin
            // dispatch with nothing served
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ctsch_pkg::ST_EMPTY;
          end
        endcase
      end else begin
        idx_nxt   = idx_r + SLOT_W'(1);
        state_nxt = S_SCAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      used_r      <= '0;
      pnz_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      used_r      <= used_nxt;
      pnz_r       <= pnz_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

[rtl/core/ctsch_checker.sv]
`default_nettype none

// Port-level checks of the scheduler
module ctsch_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire ctsch_pkg::out_item_t out_item
);

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // every result comes from an item that was being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  // more dispatch results pending: block still working
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result while idle");

  // empty dispatch is a single result at slot zero
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ctsch_pkg::ST_EMPTY)
      |-> out_item.last && (out_item.slot_index == '0))
    else $error("malformed empty dispatch result");

  // errors always close the item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ctsch_pkg::ST_ERR) |-> out_item.last)
    else $error("error result not final");

endmodule

bind cooperative_task_scheduler ctsch_checker u_ctsch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

[test/ctsch_result_checker.sv]
`default_nettype none

// Watches both channels of the scheduler, keeps its own copy of the task table
// and compares every result strobe with the oldest outstanding prediction.
module ctsch_result_checker #(
  parameter int NUM_SLOTS      = ctsch_pkg::NUM_SLOTS_DEF,
  parameter int RUN_COUNT_BITS = ctsch_pkg::RUN_COUNT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire ctsch_pkg::in_item_t  in_item,
  input  wire logic                 out_valid,
  input  wire ctsch_pkg::out_item_t out_item,
  output int                        fail_count,
  output int                        due_count
);

  // Shadow task table
  logic                          occupied  [NUM_SLOTS];
  logic [ctsch_pkg::TICK_W-1:0]  countdown [NUM_SLOTS];
  logic [ctsch_pkg::TICK_W-1:0]  reload    [NUM_SLOTS];
  logic [RUN_COUNT_BITS-1:0]     runs_owed [NUM_SLOTS];

  // Results still to come, oldest first
  ctsch_pkg::out_item_t due_results [$];

  function automatic void free_slot(input int i);
    occupied[i]  = 1'b0;
    countdown[i] = '0;
    reload[i]    = '0;
    runs_owed[i] = '0;
  endfunction

  function automatic ctsch_pkg::out_item_t make_result(
    input ctsch_pkg::status_t st, input int idx, input logic fin);
    ctsch_pkg::out_item_t r;
    r.status     = st;
    r.slot_index = idx[ctsch_pkg::SLOT_FIELD_W-1:0];
    r.last       = fin;
    return r;
  endfunction

  // Apply one accepted item to the shadow table and queue what it should produce
  task automatic advance_task_table(input ctsch_pkg::in_item_t it);
    ctsch_pkg::out_item_t prev;
    logic                 have_prev;
    logic                 placed;
    int                   served;
    int                   sel;
    have_prev = 1'b0;
    placed    = 1'b0;
    served    = 0;
    sel       = int'(it.slot);
    case (it.mode)
      ctsch_pkg::MODE_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (occupied[i]) begin
            if (countdown[i] == '0) begin
              // saturating run count
              if (runs_owed[i] != '1)
                runs_owed[i] = runs_owed[i] + 1'b1;
              if (reload[i] != '0)
                countdown[i] = reload[i];
            end else begin
              countdown[i] = countdown[i] - 1'b1;
            end
          end
        end
        due_results.push_back(make_result(ctsch_pkg::ST_OK, 0, 1'b1));
      end
      ctsch_pkg::MODE_ADD: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !occupied[i]) begin
            placed       = 1'b1;
            occupied[i]  = 1'b1;
            countdown[i] = it.delay_ticks;
            reload[i]    = it.period_ticks;
            runs_owed[i] = '0;
            due_results.push_back(make_result(ctsch_pkg::ST_OK, i, 1'b1));
          end
        end
        if (!placed)
          due_results.push_back(make_result(ctsch_pkg::ST_ERR, 0, 1'b1));
      end
      ctsch_pkg::MODE_DEL: begin
        if (sel < NUM_SLOTS && occupied[sel]) begin
          free_slot(sel);
          due_results.push_back(make_result(ctsch_pkg::ST_OK, sel, 1'b1));
        end else begin
          due_results.push_back(make_result(ctsch_pkg::ST_ERR, sel, 1'b1));
        end
      end
      default: begin
        // dispatch: one result per ready slot, last flag on the final one
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (served < ctsch_pkg::MAX_RESULTS && occupied[i] && runs_owed[i] != '0) begin
            runs_owed[i] = runs_owed[i] - 1'b1;
            if (reload[i] == '0)
              free_slot(i);
            if (have_prev)
              due_results.push_back(prev);
            prev      = make_result(ctsch_pkg::ST_OK, i, 1'b0);
            have_prev = 1'b1;
            served++;
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          due_results.push_back(prev);
        end else begin
          due_results.push_back(make_result(ctsch_pkg::ST_EMPTY, 0, 1'b1));
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    ctsch_pkg::out_item_t want;
    logic                 bad;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++)
        free_slot(i);
      due_results.delete();
      fail_count = 0;
    end else begin
      // compare the result strobe first; it always belongs to an older item
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: status=%0d slot_index=%0d last=%0d",
                   $time, out_item.status, out_item.slot_index, out_item.last);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          bad  = 1'b0;
          if (out_item.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, out_item.status);
            bad = 1'b1;
          end
          if (out_item.slot_index !== want.slot_index) begin
            $display("%0t: slot_index mismatch: expected %0d, got %0d",
                     $time, want.slot_index, out_item.slot_index);
            bad = 1'b1;
          end
          if (out_item.last !== want.last) begin
            $display("%0t: last mismatch: expected %0d, got %0d",
                     $time, want.last, out_item.last);
            bad = 1'b1;
          end
          if (bad)
            fail_count++;
        end
      end
      if (start && !busy)
        advance_task_table(in_item);
    end
    due_count <= due_results.size();
  end

endmodule

`default_nettype wire

[test/tb_cooperative_task_scheduler.sv]
`default_nettype none

module tb_cooperative_task_scheduler;

  localparam int SLOTS    = ctsch_pkg::NUM_SLOTS_DEF;
  // worst item: every slot read and rewritten, plus the output register
  localparam int DRAIN_CY = 2 * SLOTS + 8;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ctsch_pkg::in_item_t  in_item;
  logic                 out_valid;
  ctsch_pkg::out_item_t out_item;
  int                   fail_count;
  int                   due_count;
  int                   calm_left;

  cooperative_task_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  ctsch_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .fail_count (fail_count),
    .due_count  (due_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("cooperative_task_scheduler test failed");
    $finish;
  end

  // Present one item and hold it until the block takes it; start stays high
  task automatic issue(input ctsch_pkg::mode_t m, input logic [31:0] d,
                       input logic [31:0] p, input logic [2:0] s);
    in_item <= '{mode: m, delay_ticks: d, period_ticks: p, slot: s};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Random gap between items: mostly none or short, a few long, some calm stretches
  task automatic pause();
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (calm_left > 0)
      calm_left--;
    else if (r < 3)
      calm_left = $urandom_range(10, 30);
    else if (r < 55)
      gap = 0;
    else if (r < 93)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic do_item(input ctsch_pkg::mode_t m, input logic [31:0] d,
                         input logic [31:0] p, input logic [2:0] s);
    issue(m, d, p, s);
    pause();
  endtask

  // Commands whose payload is ignored still carry random fields
  task automatic do_bare(input ctsch_pkg::mode_t m);
    do_item(m, $urandom, $urandom, 3'($urandom_range(0, 7)));
  endtask

  // Mostly short delays and periods so slots fire often; some full-range values
  task automatic random_add();
    logic [31:0] d;
    logic [31:0] p;
    int          r;
    r = $urandom_range(0, 9);
    d = $urandom_range(0, 4);
    p = $urandom_range(0, 4);
    if (r == 0)
      d = $urandom;
    else if (r == 1)
      p = $urandom;
    else if (r == 2) begin
      d = $urandom;
      p = $urandom;
    end
    do_item(ctsch_pkg::MODE_ADD, d, p, 3'($urandom_range(0, 7)));
  endtask

  initial begin
    int r;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    calm_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: tick, nothing ready, delete of an empty slot
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_DISP);
    do_item(ctsch_pkg::MODE_DEL, '1, '1, 3'd7);
    // fill every slot, field extremes included
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd0, 3'd0);
    do_item(ctsch_pkg::MODE_ADD, '1, '1, 3'd7);
    do_item(ctsch_pkg::MODE_ADD, 32'd1, 32'd1, 3'd0);
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd3, 3'd5);
    do_item(ctsch_pkg::MODE_ADD, 32'd2, 32'd0, 3'd2);
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd1, 3'd1);
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd2, 3'd6);
    do_item(ctsch_pkg::MODE_ADD, 32'd5, '1, 3'd4);
    // add to a full table
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd0, 3'd3);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_DISP);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_DISP);
    // delete by index, then the same index again
    do_item(ctsch_pkg::MODE_DEL, $urandom, $urandom, 3'd1);
    do_item(ctsch_pkg::MODE_DEL, $urandom, $urandom, 3'd1);
    do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd0, 3'd0);
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_DISP);

    // every slot ready at once: a dispatch with a full burst of results
    for (int i = 0; i < SLOTS; i++)
      do_item(ctsch_pkg::MODE_DEL, $urandom, $urandom, i[2:0]);
    for (int i = 0; i < SLOTS; i++)
      do_item(ctsch_pkg::MODE_ADD, 32'd0, 32'd1, 3'($urandom_range(0, 7)));
    do_bare(ctsch_pkg::MODE_TICK);
    do_bare(ctsch_pkg::MODE_DISP);

    // random traffic
    repeat (188) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        do_bare(ctsch_pkg::MODE_TICK);
      else if (r < 65)
        random_add();
      else if (r < 80)
        do_bare(ctsch_pkg::MODE_DEL);
      else
        do_bare(ctsch_pkg::MODE_DISP);
    end

    // drain
    start <= 1'b0;
    do @(negedge clk); while (due_count != 0);
    repeat (DRAIN_CY) @(negedge clk);
    if (fail_count == 0 && due_count == 0)
      $display("cooperative_task_scheduler test passed");
    else
      $display("cooperative_task_scheduler test failed");
    $finish;
  end

endmodule

`default_nettype wire
